/* hw/rtl/arct_pkg.sv */
package arct_pkg;

  localparam int unsigned AngleW   = 32;
  localparam int unsigned HeightW  = 23;
  localparam int unsigned LevelsW  = 4;
  localparam int unsigned OutW     = 48;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TanW     = 57;  // signed Q24.32 held in 57 bits
  localparam int unsigned DivW     = 64;  // divider quotient/operand width

  localparam logic [AngleW-1:0]  AngleMaxCode = 32'd1503238553;
  localparam logic [HeightW-1:0] HeightReset  = 23'd98304;
  localparam logic [LevelsW-1:0] LevelsReset  = 4'd8;

  localparam logic [DivW-1:0] TanMax  = 64'h007F_FFFF_FFFF_FFFF;
  localparam logic [DivW-1:0] TanMinM = 64'h0080_0000_0000_0000;
  localparam logic [DivW-1:0] OutMax  = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusAlphaBad  = 2'd1;
  localparam logic [StatusW-1:0] StatusBetaBad   = 2'd2;

  localparam logic CfgIdxHeight = 1'b0;
  localparam logic CfgIdxLevels = 1'b1;

  // Divider operand selection.
  localparam logic [2:0] DivStart  = 3'd0;  // a*4 / (2n+1)
  localparam logic [2:0] DivKOverA = 3'd1;  // k*2^62 / a
  localparam logic [2:0] DivRecip  = 3'd2;  // 2^64 / |y|
  localparam logic [2:0] DivDist   = 3'd3;  // h*2^32 / T

  typedef struct packed {
    logic       div_go;
    logic [2:0] div_op;
    logic       sel_beta;
    logic       tan_init;
    logic       lvl_sub;
    logic       lvl_recip;
    logic       dist_save;
    logic       tan_save_a;
    logic       mul_go;
    logic       fin;
  } arct_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic lvl_last;
  } arct_sts_t;

endpackage

/* hw/rtl/arct_div.sv */
module arct_div import arct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [127:0]    num_i,
  input  logic [DivW-1:0] den_i,
  input  logic [DivW-1:0] lim_i,
  output logic            done_o,
  output logic [DivW-1:0] quo_o
);
  // Restoring divider, one numerator bit a cycle; result clamped to lim.
  logic [127:0]    num_q, num_d;
  logic [DivW:0]   rem_q, rem_d;
  logic [DivW-1:0] den_q, den_d, lim_q, lim_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW+1:0] trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; lim_d = lim_q;
    quo_d = quo_q; ovf_d = ovf_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (go_i) begin
      num_d = num_i; den_d = den_i; lim_d = lim_i; rem_d = '0; quo_d = '0;
      ovf_d = 1'b0; cnt_d = 8'd128; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[127]} - {2'b00, den_q};
      num_d = {num_q[126:0], 1'b0};
      if (!trial[DivW+1]) begin
        rem_d = trial[DivW:0];
      end else begin
        rem_d = {rem_q[DivW-1:0], num_q[127]};
      end
      ovf_d = ovf_q | quo_q[DivW-1];
      quo_d = {quo_q[DivW-2:0], ~trial[DivW+1]};
      cnt_d = cnt_q - 8'd1;
      if (cnt_q == 8'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; lim_q <= lim_d;
    quo_q <= quo_d; ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == '0 || ovf_q || quo_q > lim_q) ? lim_q : quo_q;
endmodule

/* hw/rtl/arct_datapath.sv */
module arct_datapath import arct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [AngleW-1:0]  alpha_i,
  input  logic [AngleW-1:0]  beta_i,
  input  logic [HeightW-1:0] height_i,
  input  logic [LevelsW-1:0] levels_i,
  input  arct_cmd_t          cmd_i,
  output arct_sts_t          sts_o,
  output logic [OutW-1:0]    distance_o,
  output logic [OutW-1:0]    height_o
);
  logic [AngleW-1:0]  alpha_q, beta_q, ang;
  logic [HeightW-1:0] h_q;
  logic [LevelsW-1:0] n_q, lvl_q, lvl_d;
  logic [TanW-1:0]    val_q, val_d, y_q, y_d, ta_q, ta_d;
  logic [OutW-1:0]    dist_q, dist_d;
  logic [OutW-1:0]    obj_q, obj_d;
  logic [127:0]       num;
  logic [DivW-1:0]    den, lim, quo;
  logic               div_done;
  logic [TanW:0]      diff;
  logic [DivW-1:0]    ymag;

  // Multiplier: tangent magnitude times the distance, one 16-bit digit at a time over three digits.
  logic [2:0]         mcnt_q, mcnt_d;
  logic               mbusy_q, mbusy_d, mdone_q, mdone_d;
  logic [63:0]        tmag_q, tmag_d;
  logic [111:0]       acc_q, acc_d;
  logic [15:0]        mdig;
  logic [71:0]        pp;
  logic               tneg_q, tneg_d;
  logic [111:0]       prod;
  logic [OutW:0]      m48, sum;

  assign ang = cmd_i.sel_beta ? beta_q : alpha_q;
  assign ymag = y_q[TanW-1] ? DivW'(-$signed(y_q)) : DivW'(y_q);

  always_comb begin
    num = '0; den = '0; lim = TanMax;
    case (cmd_i.div_op)
      DivStart: begin
        num = 128'({ang, 2'b00});
        den = 64'({n_q, 1'b1});
      end
      DivKOverA: begin
        num = 128'({lvl_q, 1'b0} - 5'd1) << 62;
        den = 64'(ang);
      end
      DivRecip: begin
        num = 128'd1 << 64;
        den = ymag;
        lim = y_q[TanW-1] ? TanMinM : TanMax;
      end
      DivDist: begin
        num = 128'(h_q) << 32;
        den = 64'(ta_q);
        lim = OutMax;
      end
      default: ;
    endcase
  end

  arct_div u_div (
    .clk_i, .rst_ni, .go_i(cmd_i.div_go), .num_i(num), .den_i(den),
    .lim_i(lim), .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    val_d = val_q; y_d = y_q; lvl_d = lvl_q; ta_d = ta_q; dist_d = dist_q;
    diff = '0;
    if (cmd_i.tan_init) begin
      val_d = TanW'(quo);
      lvl_d = n_q;
    end
    if (cmd_i.lvl_sub) begin
      diff = {1'b0, TanW'(quo)} - {val_q[TanW-1], val_q};
      if (!diff[TanW] && diff[TanW-1:TanW-2] != 2'b00) y_d = TanW'(TanMax);
      else if (diff[TanW] && diff[TanW-1:TanW-2] != 2'b11) y_d = ~TanW'(TanMax);
      else y_d = diff[TanW-1:0];
    end
    if (cmd_i.lvl_recip) begin
      if (y_q == '0) val_d = TanW'(TanMax);
      else if (y_q[TanW-1]) val_d = TanW'(-$signed({1'b0, quo[TanW-2:0]}))
                                  | (quo[TanW-1] ? {1'b1, {(TanW-1){1'b0}}} : '0);
      else val_d = TanW'(quo);
      lvl_d = lvl_q - 4'd1;
    end
    if (cmd_i.tan_save_a) ta_d = val_q;
    if (cmd_i.dist_save) dist_d = ta_q[TanW-1] || ta_q == '0 ? OutW'(OutMax) : OutW'(quo);
  end

  // tan(beta)*dist/2^32 via three 16-bit digits of dist.
  assign mdig = dist_q[16*mcnt_q[1:0] +: 16];
  assign pp   = 72'(tmag_q) * 72'(mdig);
  always_comb begin
    mcnt_d = mcnt_q; mbusy_d = mbusy_q; mdone_d = 1'b0;
    tmag_d = tmag_q; acc_d = acc_q; tneg_d = tneg_q;
    if (cmd_i.mul_go) begin
      tneg_d = val_q[TanW-1];
      tmag_d = val_q[TanW-1] ? 64'(-$signed(val_q)) : 64'(val_q);
      acc_d = '0; mcnt_d = 3'd0; mbusy_d = 1'b1;
    end else if (mbusy_q) begin
      acc_d = acc_q + (112'(pp) << (16*mcnt_q[1:0]));
      mcnt_d = mcnt_q + 3'd1;
      if (mcnt_q == 3'd2) begin
        mbusy_d = 1'b0;
        mdone_d = 1'b1;
      end
    end
  end

  assign prod = acc_q;
  assign m48 = prod[111:80] != '0 ? {1'b0, OutMax[OutW-1:0]} : {1'b0, prod[79:32]};
  assign sum = tneg_q ? ({1'b0, OutW'(h_q)} - m48) : (m48 + OutW'(h_q));

  always_comb begin
    obj_d = obj_q;
    if (mdone_q) begin
      if (tneg_q) obj_d = m48 >= (OutW+1)'(h_q) ? '0 : sum[OutW-1:0];
      else obj_d = sum[OutW] ? OutMax[OutW-1:0] : sum[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0; mdone_q <= 1'b0; mcnt_q <= '0;
    end else begin
      mbusy_q <= mbusy_d; mdone_q <= mdone_d; mcnt_q <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      alpha_q <= alpha_i; beta_q <= beta_i; h_q <= height_i; n_q <= levels_i;
    end
    val_q <= val_d; y_q <= y_d; lvl_q <= lvl_d; ta_q <= ta_d;
    dist_q <= dist_d; obj_q <= obj_d; tmag_q <= tmag_d; acc_q <= acc_d;
    tneg_q <= tneg_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mdone_q;
  assign sts_o.lvl_last = (lvl_q == '0);
  assign distance_o = dist_q;
  assign height_o   = obj_q;
endmodule

/* hw/rtl/arct_ctrl.sv */
module arct_ctrl import arct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      ok_i,
  input  logic      beta_i,
  input  arct_sts_t sts_i,
  output logic      busy_o,
  output logic      load_o,
  output arct_cmd_t cmd_o
);
  localparam logic [3:0] SIdle = 4'd0, SChk = 4'd1, SInit = 4'd2, SKa = 4'd3,
                         SRec = 4'd4, SDist = 4'd5, SMul = 4'd6, SDone = 4'd7,
                         SInitW = 4'd8, SKaW = 4'd9, SRecW = 4'd10, SDistW = 4'd11,
                         SMulW = 4'd12, SMulF = 4'd13;
  logic [3:0] st_q, st_d;
  logic       b_q, b_d, bp_q, bp_d;

  always_comb begin
    st_d = st_q; b_d = b_q; bp_d = bp_q; cmd_o = '0; load_o = 1'b0;
    cmd_o.sel_beta = b_q;
    case (st_q)
      SIdle: if (start_i) begin
        load_o = 1'b1; bp_d = beta_i; b_d = 1'b0; st_d = SChk;
      end
      SChk: st_d = ok_i ? SInit : SDone;
      SInit: begin
        cmd_o.div_go = 1'b1; cmd_o.div_op = DivStart; st_d = SInitW;
      end
      SInitW: begin
        cmd_o.div_op = DivStart;
        if (sts_i.div_done) begin
          cmd_o.tan_init = 1'b1; st_d = SKa;
        end
      end
      SKa: if (sts_i.lvl_last) begin
        if (!b_q) begin
          cmd_o.tan_save_a = 1'b1; st_d = SDist;
        end else st_d = SMul;
      end else begin
        cmd_o.div_go = 1'b1; cmd_o.div_op = DivKOverA; st_d = SKaW;
      end
      SKaW: begin
        cmd_o.div_op = DivKOverA;
        if (sts_i.div_done) begin
          cmd_o.lvl_sub = 1'b1; st_d = SRec;
        end
      end
      SRec: begin
        cmd_o.div_go = 1'b1; cmd_o.div_op = DivRecip; st_d = SRecW;
      end
      SRecW: begin
        cmd_o.div_op = DivRecip;
        if (sts_i.div_done) begin
          cmd_o.lvl_recip = 1'b1; st_d = SKa;
        end
      end
      SDist: begin
        cmd_o.div_go = 1'b1; cmd_o.div_op = DivDist; st_d = SDistW;
      end
      SDistW: begin
        cmd_o.div_op = DivDist;
        if (sts_i.div_done) begin
          cmd_o.dist_save = 1'b1;
          if (bp_q) begin
            b_d = 1'b1; st_d = SInit;
          end else st_d = SDone;
        end
      end
      SMul: begin
        cmd_o.mul_go = 1'b1; st_d = SMulW;
      end
      SMulW: if (sts_i.mul_done) st_d = SMulF;
      SMulF: st_d = SDone;
      SDone: begin
        cmd_o.fin = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; b_q <= 1'b0; bp_q <= 1'b0;
    end else begin
      st_q <= st_d; b_q <= b_d; bp_q <= bp_d;
    end
  end

  assign busy_o = (st_q != SIdle);

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> busy_o) else $error("finish outside a job");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> busy_o) else $error("job not started");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> !busy_o) else $error("not idle after finish");
endmodule

/* hw/rtl/angle_rangefinder_cfrac_tan.sv */
// Run time grows with the level count n, and a beta angle adds a second pass through
// the levels and a multiply; a rejected angle skips the divider and gives its result early.
// All divisions run on the one shared bit-serial divider, which sets the pace.
// Throughput: one measurement at a time; the next word may start while done_o is high.
// done_o is high for one cycle and the results hold until the next finish; the receiver cannot stall.
// Reset (rst_ni, asynchronous) returns the registers to 1.5 m and 8 levels.
module angle_rangefinder_cfrac_tan import arct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [AngleW-1:0]  alpha_angle_i,
  input  logic [AngleW-1:0]  beta_angle_i,
  input  logic               beta_present_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic [OutW-1:0]    distance_o,
  output logic [OutW-1:0]    object_height_o,
  output logic               height_valid_o,
  output logic [StatusW-1:0] status_o
);
  logic [HeightW-1:0] height_q;
  logic [LevelsW-1:0] levels_q;
  logic [StatusW-1:0] st_q, st_d;
  logic               bp_q, load;
  arct_cmd_t          cmd;
  arct_sts_t          sts;
  logic [OutW-1:0]    dp_distance, obj;
  logic               a_ok, b_ok;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset; levels_q <= LevelsReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxHeight) height_q <= cfg_data_i[HeightW-1:0];
      else levels_q <= cfg_data_i[LevelsW-1:0];
    end
  end

  assign a_ok = alpha_angle_i != '0 && alpha_angle_i <= AngleMaxCode;
  assign b_ok = !beta_present_i || (beta_angle_i != '0 && beta_angle_i <= AngleMaxCode);
  assign st_d = !a_ok ? StatusAlphaBad : (!b_ok ? StatusBetaBad : StatusOk);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StatusOk; bp_q <= 1'b0; done_o <= 1'b0;
    end else begin
      if (load) begin
        st_q <= st_d; bp_q <= beta_present_i;
      end
      done_o <= cmd.fin;
    end
  end

  arct_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .ok_i(st_q == StatusOk), .beta_i(beta_present_i),
    .sts_i(sts), .busy_o(busy), .load_o(load), .cmd_o(cmd)
  );

  arct_datapath u_dp (
    .clk_i, .rst_ni, .load_i(load), .alpha_i(alpha_angle_i), .beta_i(beta_angle_i),
    .height_i(height_q), .levels_i(levels_q), .cmd_i(cmd), .sts_o(sts),
    .distance_o(dp_distance), .height_o(obj)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.fin) begin
      distance_o      <= (st_q == StatusOk) ? dp_distance : '0;
      object_height_o <= (st_q == StatusOk && bp_q) ? obj : '0;
      height_valid_o  <= (st_q == StatusOk) && bp_q;
      status_o        <= st_q;
    end
  end
endmodule

/* bench/range_checker.sv */
`timescale 1ns / 100ps
module range_checker import arct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [AngleW-1:0]  alpha_angle_i,
  input  logic [AngleW-1:0]  beta_angle_i,
  input  logic               beta_present_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               done_i,
  input  logic [OutW-1:0]    distance_i,
  input  logic [OutW-1:0]    object_height_i,
  input  logic               height_valid_i,
  input  logic [StatusW-1:0] status_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o,
  output int                 checked_count_o
);

  typedef struct packed {
    logic [OutW-1:0]    distance;
    logic [OutW-1:0]    object_height;
    logic               height_valid;
    logic [StatusW-1:0] status;
  } range_result_t;

  range_result_t       expected_q[$];
  logic [HeightW-1:0]  height_reg;
  logic [LevelsW-1:0]  levels_reg;

  // min(floor(n * 2^s / d), lim), with a zero divisor giving lim
  function automatic logic [63:0] scaled_quotient(logic [63:0] n, int s, logic [63:0] d,
                                                  logic [63:0] lim);
    logic [63:0] q;
    logic [63:0] r;
    if (d == 0) return lim;
    q = n / d;
    r = n % d;
    if (q > lim) return lim;
    for (int i = 0; i < s; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > lim) return lim;
    end
    return q;
  endfunction

  function automatic logic signed [63:0] clamp_tan(logic signed [63:0] v);
    if (v > $signed(TanMax)) return $signed(TanMax);
    if (v < -$signed(TanMinM)) return -$signed(TanMinM);
    return v;
  endfunction

  // Lambert continued fraction, evaluated from the innermost level outwards.
  function automatic logic signed [63:0] lambert_tan(logic [AngleW-1:0] a,
                                                     logic [LevelsW-1:0] levels);
    logic signed [63:0] val;
    logic signed [63:0] q;
    logic signed [63:0] y;
    logic [63:0] k;
    val = $signed(({32'd0, a} << 2) / (2 * {60'd0, levels} + 1));
    for (int i = levels; i >= 1; i--) begin
      k = 64'(2 * i - 1);
      q = $signed(scaled_quotient(k, 62, {32'd0, a}, TanMax));
      y = clamp_tan(q - val);
      if (y == 0)
        val = $signed(TanMax);
      else if (y > 0)
        val = $signed(scaled_quotient(64'd1, 64, y, TanMax));
      else
        val = -$signed(scaled_quotient(64'd1, 64, -y, TanMinM));
    end
    return val;
  endfunction

  function automatic logic [63:0] scaled_product(logic [63:0] t, logic [63:0] d);
    logic [127:0] p;
    p = ({64'd0, t} * {64'd0, d}) >> 32;
    return (p > {64'd0, OutMax}) ? OutMax : p[63:0];
  endfunction

  function automatic range_result_t predict_range(logic [AngleW-1:0] alpha,
                                                  logic [AngleW-1:0] beta, logic bp);
    range_result_t      res;
    logic signed [63:0] ta;
    logic signed [63:0] tb;
    logic [63:0]        dist_est;
    logic [63:0]        obj;
    logic [63:0]        m;
    logic [63:0]        h;
    res = '0;
    h = {41'd0, height_reg};
    if (alpha == 0 || alpha > AngleMaxCode) begin
      res.status = StatusAlphaBad;
    end else if (bp && (beta == 0 || beta > AngleMaxCode)) begin
      res.status = StatusBetaBad;
    end else begin
      res.status = StatusOk;
      ta = lambert_tan(alpha, levels_reg);
      dist_est = (ta <= 0) ? OutMax : scaled_quotient(h, 32, ta, OutMax);
      res.distance = dist_est[OutW-1:0];
      if (bp) begin
        tb = lambert_tan(beta, levels_reg);
        if (tb >= 0) begin
          obj = scaled_product(tb, dist_est) + h;
          if (obj > OutMax) obj = OutMax;
        end else begin
          m = scaled_product(-tb, dist_est);
          obj = (m >= h) ? 64'd0 : h - m;
        end
        res.object_height = obj[OutW-1:0];
        res.height_valid  = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    range_result_t want;
    if (!rst_ni) begin
      height_reg = HeightReset;
      levels_reg = LevelsReset;
      expected_q.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
    end else begin
      // A word that finishes in this cycle was accepted under the old settings.
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, distance", distance_i, 0);
        end else begin
          want = expected_q.pop_front();
          checked_count_o++;
          if (distance_i !== want.distance)
            report_mismatch("distance", distance_i, want.distance);
          if (height_valid_i !== want.height_valid)
            report_mismatch("height_valid", height_valid_i, want.height_valid);
          if (object_height_i !== want.object_height)
            report_mismatch("object_height", object_height_i, want.object_height);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_range(alpha_angle_i, beta_angle_i, beta_present_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgIdxHeight) height_reg = cfg_data_i[HeightW-1:0];
        else                             levels_reg = cfg_data_i[LevelsW-1:0];
      end
    end
    pending_count_o = expected_q.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
module tb;
  import arct_pkg::*;

  localparam int WatchdogLimit = 60000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [AngleW-1:0]  alpha_angle = '0;
  logic [AngleW-1:0]  beta_angle = '0;
  logic               beta_present = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CfgIdxHeight;
  logic [31:0]        cfg_data = '0;
  logic               done;
  logic [OutW-1:0]    distance;
  logic [OutW-1:0]    object_height;
  logic               height_valid;
  logic [StatusW-1:0] status;
  int                 mismatches;
  int                 pending;
  int                 checked;
  int                 idle_cycles_left;
  bit                 idling_on = 1'b1;
  int                 items_sent = 0;
  int                 cfg_writes = 0;

  always #2 clk_i = ~clk_i;

  angle_rangefinder_cfrac_tan dut (
    .clk_i, .rst_ni, .start, .busy,
    .alpha_angle_i(alpha_angle), .beta_angle_i(beta_angle),
    .beta_present_i(beta_present),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_o(done), .distance_o(distance), .object_height_o(object_height),
    .height_valid_o(height_valid), .status_o(status)
  );

  range_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .alpha_angle_i(alpha_angle), .beta_angle_i(beta_angle),
    .beta_present_i(beta_present),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_i(done), .distance_i(distance), .object_height_i(object_height),
    .height_valid_i(height_valid), .status_i(status),
    .mismatch_count_o(mismatches), .pending_count_o(pending),
    .checked_count_o(checked)
  );

  // Any accepted word on any channel resets the watchdog.
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic measure(logic [AngleW-1:0] a, logic [AngleW-1:0] b, logic bp);
    if (idling_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      idle_cycles_left = $urandom_range(1, 8);
      repeat (idle_cycles_left) @(posedge clk_i);
    end
    alpha_angle  <= a;
    beta_angle   <= b;
    beta_present <= bp;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic write_setting(logic idx, logic [31:0] data);
    start <= 1'b0;
    // Waiting for a clock edge lets the checker record the word accepted just before.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return $urandom_range(1, AngleMaxCode);
    if (sel < 86) return $urandom;
    if (sel < 90) return AngleMaxCode - $urandom_range(3);
    if (sel < 94) return $urandom_range(1, 64);
    if (sel < 97) return AngleMaxCode + $urandom_range(1, 4);
    return '0;
  endfunction

  task automatic random_phase(int count);
    logic [AngleW-1:0] b;
    for (int i = 0; i < count; i++) begin
      b = pick_angle();
      measure(pick_angle(), b, $urandom_range(99) < 70);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings.
    measure('0, 32'd1000, 1'b1);
    measure(AngleMaxCode + 1, 32'd1000, 1'b1);
    measure('1, '1, 1'b0);
    measure(32'd1, 32'd1, 1'b1);
    measure(AngleMaxCode, AngleMaxCode, 1'b1);
    measure(32'd536870912, '0, 1'b1);
    measure(32'd536870912, AngleMaxCode + 1, 1'b1);
    measure(32'd536870912, '1, 1'b0);
    measure(32'd843314857, 32'd268435456, 1'b1);
    measure(32'd100, AngleMaxCode, 1'b1);
    write_setting(CfgIdxLevels, 32'd0);
    measure(32'd1073741824, 32'd536870912, 1'b1);
    measure(AngleMaxCode, AngleMaxCode, 1'b1);
    write_setting(CfgIdxLevels, 32'hFFFF_FFFF);
    measure(AngleMaxCode, 32'd1, 1'b1);
    measure(32'd1, AngleMaxCode, 1'b1);
    write_setting(CfgIdxHeight, 32'd0);
    measure(32'd536870912, 32'd536870912, 1'b1);
    write_setting(CfgIdxHeight, 32'hFF80_0000 | 32'd6553600);
    write_setting(CfgIdxLevels, 32'd13);
    measure(32'd1, AngleMaxCode, 1'b1);
    measure(AngleMaxCode, AngleMaxCode, 1'b1);

    // Random phases; most settings keep the level count small so the run stays short.
    write_setting(CfgIdxHeight, 32'd1);
    write_setting(CfgIdxLevels, 32'd1);
    random_phase(100);
    write_setting(CfgIdxHeight, 32'd98304);
    write_setting(CfgIdxLevels, 32'd8);
    idling_on = 1'b0;
    random_phase(100);
    idling_on = 1'b1;
    write_setting(CfgIdxHeight, 32'h007F_FFFF);
    write_setting(CfgIdxLevels, 32'd2);
    random_phase(100);
    write_setting(CfgIdxHeight, $urandom);
    write_setting(CfgIdxLevels, 32'd3);
    random_phase(100);
    write_setting(CfgIdxHeight, $urandom_range(1, 6553600));
    write_setting(CfgIdxLevels, $urandom_range(0, 15));
    random_phase(100);
    write_setting(CfgIdxHeight, 32'd6553600);
    write_setting(CfgIdxLevels, 32'd15);
    random_phase(40);
    write_setting(CfgIdxLevels, 32'd0);
    random_phase(60);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d measurements and %0d register writes; %0d results checked.",
             items_sent, cfg_writes, checked);
    $display("Settings covered zero to fifteen levels and heights from zero to full scale.");
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
